@@ rtl/core/edb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Equal-depth bin builder package
// Shared widths, register indexes, the sequencer state type and the result
// record.
// ----------------------------------------------------------------------------
package edb_pkg;

  localparam int DATA_WIDTH          = 32;
  localparam int COUNT_WIDTH_DEFAULT = 32;

  localparam logic REG_ITEM_COUNT  = 1'b0;
  localparam logic REG_BINS_WANTED = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_OPEN,
    ST_DIV,
    ST_BOUND,
    ST_POST
  } edb_state_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] low;
    logic signed [DATA_WIDTH-1:0] high;
    logic        [DATA_WIDTH-1:0] count;
    logic                         last;
  } bin_result_t;

endpackage : edb_pkg
`default_nettype wire

@@ rtl/core/equal_depth_bin_builder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Equal-depth bin builder
// Cuts an ascending stream of signed values into equal-depth bins and
// reports each bin (low, high, count, last flag) as it closes.
// ----------------------------------------------------------------------------
// Sequence: an item that opens no bin passes accept, check and post; an item
//   that opens a bin also passes open, the one-bit-a-cycle divider that sizes
//   each new bin, and bound before post. A new item is taken only in idle.
// Queueing: a closing bin is queued in the cycle after its request is accepted,
//   the final bin in post, after the divider and bound when a bin opens.
// Reset: clears the sequencer, the result queue and the stream state, and
//   loads item_count = 1 and bins_wanted = 2. A register write also
//   restarts the stream.
// ----------------------------------------------------------------------------
module equal_depth_bin_builder
  import edb_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // configuration
  input  wire logic                         cfg_write,
  input  wire logic                         cfg_index,
  input  wire logic        [DATA_WIDTH-1:0] cfg_data,
  // input requests
  input  wire logic                         item_valid,
  output logic                              item_stall,
  input  wire logic signed [DATA_WIDTH-1:0] value,
  // result requests
  output logic                              bin_valid,
  input  wire logic                         bin_stall,
  output logic signed      [DATA_WIDTH-1:0] bin_low,
  output logic signed      [DATA_WIDTH-1:0] bin_high,
  output logic             [DATA_WIDTH-1:0] bin_count,
  output logic                              last_bin
);

  // counters are held to COUNT_WIDTH bits, and never beyond the 32-bit
  // registers
  localparam int CW = (COUNT_WIDTH > DATA_WIDTH) ? DATA_WIDTH : COUNT_WIDTH;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [CW-1:0] item_count;
  logic [CW-1:0] bins_wanted;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_count  <= CW'(1);
      bins_wanted <= CW'(2);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ITEM_COUNT:  item_count  <= cfg_data[CW-1:0];
        REG_BINS_WANTED: bins_wanted <= cfg_data[CW-1:0];
        default:         ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Stream state
  // ---------------------------------------------------------------------
  edb_state_t        state;
  edb_state_t        state_next;

  logic [CW-1:0]     item_index;
  logic [CW-1:0]     bin_start_index;
  logic [CW-1:0]     target_stop_index;
  logic [CW-1:0]     bins_made;
  logic [CW-1:0]     wanted_eff;
  logic [DATA_WIDTH-1:0] current_low;
  logic [DATA_WIDTH-1:0] closing_value;
  logic [DATA_WIDTH-1:0] item_value;
  logic              final_bin_flag;

  // check-state decisions, all side by side on registered state
  logic              past_end;
  logic              first_item;
  logic              close_bin;
  logic [CW-1:0]     wanted_clamped;

  // divider hookup
  logic              div_start;
  logic              div_done;
  logic [CW-1:0]     div_dividend;
  logic [CW-1:0]     div_divisor;
  logic [CW-1:0]     div_quotient;
  logic [CW-1:0]     bin_depth;

  // result queue
  bin_result_t       queue [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  logic              push;
  logic              pop;
  bin_result_t       push_data;
  bin_result_t       head;

  logic              item_take;
  logic              last_item;

  assign item_take  = item_valid && !item_stall;
  // accept only with room for the two bins a single item can close
  assign item_stall = !(state == ST_IDLE && fill <= (QPTR_W + 1)'(QDEPTH - 2));

  assign past_end   = item_index >= item_count;
  assign first_item = item_index == '0;
  assign close_bin  = !final_bin_flag && item_index > target_stop_index &&
                      item_value != closing_value;
  assign last_item  = item_index == item_count - 1'b1;

  always_comb begin
    wanted_clamped = (bins_wanted == '0) ? CW'(1) : bins_wanted;
    if (wanted_clamped > item_count) begin
      wanted_clamped = item_count;
    end
  end

  assign div_dividend = item_count - item_index;
  assign div_divisor  = (bins_made < wanted_eff) ? wanted_eff - bins_made : CW'(1);
  assign bin_depth    = (div_quotient == '0) ? CW'(1) : div_quotient;

  edb_div #(
    .W (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    push       = 1'b0;
    push_data  = '{low: current_low, high: closing_value,
                   count: DATA_WIDTH'(item_index - bin_start_index), last: 1'b0};
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (item_take) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // drop items past the end of the stream
        if (past_end) begin
          state_next = ST_IDLE;
        end else if (first_item) begin
          state_next = ST_OPEN;
        end else if (close_bin) begin
          push       = 1'b1;
          state_next = ST_OPEN;
        end else begin
          state_next = ST_POST;
        end
      end
      ST_OPEN: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_BOUND;
        end
      end
      ST_BOUND: begin
        state_next = ST_POST;
      end
      ST_POST: begin
        if (last_item) begin
          push      = 1'b1;
          push_data = '{low: current_low, high: item_value,
                        count: DATA_WIDTH'(item_index - bin_start_index + 1'b1),
                        last: 1'b1};
        end
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Stream datapath
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      item_index        <= '0;
      bin_start_index   <= '0;
      target_stop_index <= '0;
      bins_made         <= '0;
      current_low       <= '0;
      closing_value     <= '0;
      final_bin_flag    <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (item_take) begin
            item_value <= value;
          end
        end
        ST_CHECK: begin
          wanted_eff <= wanted_clamped;
          if (!past_end) begin
            if (first_item) begin
              bins_made <= '0;
            end else if (close_bin) begin
              bins_made <= bins_made + 1'b1;
            end
          end
        end
        ST_OPEN: begin
          // open a new bin at this item
          bin_start_index <= item_index;
          current_low     <= item_value;
        end
        ST_DIV: begin
          if (div_done) begin
            target_stop_index <= bin_start_index + bin_depth;
          end
        end
        ST_BOUND: begin
          final_bin_flag <= target_stop_index >= item_count;
        end
        ST_POST: begin
          // hold the value at the target; equal items that follow stay in
          if (!final_bin_flag && item_index == target_stop_index) begin
            closing_value <= item_value;
          end
          if (last_item) begin
            bins_made <= bins_made + 1'b1;
          end
          item_index <= item_index + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Result queue
  // ---------------------------------------------------------------------
  assign pop       = bin_valid && !bin_stall;
  assign head      = queue[rd_ptr];
  assign bin_valid = fill != '0;
  assign bin_low   = head.low;
  assign bin_high  = head.high;
  assign bin_count = head.count;
  assign last_bin  = head.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= push_data;
    end
  end

endmodule : equal_depth_bin_builder
`default_nettype wire

@@ rtl/core/edb_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Equal-depth bin builder divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module edb_div
  import edb_pkg::*;
#(
  parameter int W = COUNT_WIDTH_DEFAULT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic      [W-1:0] quotient
);

  localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

  logic [W-1:0]     rem;
  logic [W-1:0]     quo;
  logic [W-1:0]     dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [W:0]       trial;

  assign trial    = {rem, quo[W-1]} - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
      cnt <= CNT_W'(W - 1);
    end else if (busy) begin
      // keep the trial remainder when it did not go negative
      if (!trial[W]) begin
        rem <= trial[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= {rem[W-2:0], quo[W-1]};
        quo <= {quo[W-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
    end
  end

endmodule : edb_div
`default_nettype wire
